[rtl/mmpt_pkg.sv]
package mmpt_pkg;

  // Table geometry
  localparam int CAPACITY    = 64;
  localparam int ID_WIDTH    = 16;
  localparam int LEVEL_WIDTH = 7;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // Action codes
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_EMPTY  = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;
  localparam logic [1:0] STAT_ABSENT = 2'd3;

  // Commands broadcast along the cell chain
  localparam logic [1:0] CMD_HOLD   = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_INSERT = 2'd2;

  typedef struct packed {
    logic [1:0]             action;
    logic [ID_WIDTH-1:0]    entry_id;
    logic [LEVEL_WIDTH-1:0] entry_level;
    logic                   pick_hardest;
  } in_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0] result_id;
    logic [1:0]          status;
  } out_t;

  typedef struct packed {
    logic                   valid;
    logic [ID_WIDTH-1:0]    id;
    logic [LEVEL_WIDTH-1:0] level;
  } cell_t;

  typedef struct packed {
    logic [1:0]             op;
    logic [ID_WIDTH-1:0]    id;
    logic [LEVEL_WIDTH-1:0] level;
  } cmd_t;

endpackage

[rtl/mmpt_cell.sv]
module mmpt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  mmpt_pkg::cmd_t cmd,
  input  mmpt_pkg::cell_t cell_above,
  input  logic           prev_above_new,
  input  mmpt_pkg::cell_t cell_below,
  input  logic           rm_in,
  output mmpt_pkg::cell_t cell_q,
  output logic           above_new,
  output logic           rm_out
);
  import mmpt_pkg::*;

  cell_t cell_r;
  cell_t cell_nxt;
  logic  match;

  // Broadcast compares against the command's id and key
  assign match     = cell_r.valid && (cell_r.id == cmd.id);
  assign above_new = cell_r.valid &&
                     ({cell_r.level, cell_r.id} > {cmd.level, cmd.id});
  // Set from the matching cell downwards: those cells close the gap
  assign rm_out    = rm_in | match;

  always_comb begin
    cell_nxt = cell_r;
    case (cmd.op)
      CMD_REMOVE: begin
        if (rm_out) begin
          cell_nxt = cell_below;
        end
      end
      CMD_INSERT: begin
        if (!above_new) begin
          if (prev_above_new) begin
            cell_nxt.valid = 1'b1;
            cell_nxt.id    = cmd.id;
            cell_nxt.level = cmd.level;
          end else begin
            cell_nxt = cell_above;
          end
        end
      end
      default: cell_nxt = cell_r;
    endcase
  end

  // Only the valid bit is reset; id and level follow it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid <= cell_nxt.valid;
    end
    cell_r.id    <= cell_nxt.id;
    cell_r.level <= cell_nxt.level;
  end

  assign cell_q = cell_r;

endmodule

[rtl/min_max_priority_table.sv]
// Ordered table of (id, level) entries held in a chain of cells, sorted from
// the hardest entry (highest level, then highest id) in cell 0 down to the
// easiest entry in the last valid cell. Valid cells are always packed at the
// head of the chain.
// Input: a transaction is taken at a rising edge with start high and busy low.
// Actions are add/update, remove and query (hardest or easiest entry).
// Output: exactly one result per transaction, shown for one cycle with
// out_valid high; the receiver cannot stall it.
// Sequence: the search cycle, entered at the accepting edge, searches the
// chain, removes the matching cell and registers the result, so out_valid is
// high in the next cycle, the insert cycle, which puts in the new entry for
// an add, shifting the cells below it down by one. busy is high in the search
// cycle only: a new transaction can be taken in the insert cycle, not in the
// search one; the two-pass remove-then-insert over the cell chain sets that.
// Reset: synchronous, active low; all cells go invalid and the count to zero.
module min_max_priority_table (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  mmpt_pkg::in_t in_data,
  output logic          busy,
  output logic          out_valid,
  output mmpt_pkg::out_t out_data
);
  import mmpt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FIND   = 2'd1;
  localparam logic [1:0] S_INSERT = 2'd2;

  logic [1:0]     state_r, state_nxt;
  in_t            op_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic           ins_ok_r, ins_ok_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_t           out_data_r, out_data_nxt;

  cmd_t           cmd;
  cell_t          cell_q    [CAPACITY];
  logic           above_new [CAPACITY];
  logic           tail      [CAPACITY];
  logic [CAPACITY:0] rm_chain;

  logic           accept;
  logic           found;
  logic           full;
  logic           empty;
  logic [ID_WIDTH-1:0] easy_id;
  logic [ID_WIDTH-1:0] pick_id;

  assign accept = start && !busy;
  assign busy   = (state_r == S_FIND);
  assign found  = rm_chain[CAPACITY];
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);

  // Command to the chain: remove in the search cycle, insert in the next
  always_comb begin
    cmd.id    = op_r.entry_id;
    cmd.level = op_r.entry_level;
    cmd.op    = CMD_HOLD;
    if (state_r == S_FIND &&
        (op_r.action == ACT_ADD || op_r.action == ACT_REMOVE)) begin
      cmd.op = CMD_REMOVE;
    end else if (state_r == S_INSERT && op_r.action == ACT_ADD && ins_ok_r) begin
      cmd.op = CMD_INSERT;
    end
  end

  // Cell chain
  assign rm_chain[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_t c_above;
    cell_t c_below;
    logic  p_above;
    if (i == 0) begin : g_head
      assign c_above = '0;
      assign p_above = 1'b1;
    end else begin : g_mid
      assign c_above = cell_q[i-1];
      assign p_above = above_new[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign c_below = '0;
      assign tail[i] = cell_q[i].valid;
    end else begin : g_inner
      assign c_below = cell_q[i+1];
      assign tail[i] = cell_q[i].valid && !cell_q[i+1].valid;
    end
    mmpt_cell u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .cmd            (cmd),
      .cell_above     (c_above),
      .prev_above_new (p_above),
      .cell_below     (c_below),
      .rm_in          (rm_chain[i]),
      .cell_q         (cell_q[i]),
      .above_new      (above_new[i]),
      .rm_out         (rm_chain[i+1])
    );
  end

  // Easiest entry: one-hot select of the last valid cell
  always_comb begin
    easy_id = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      easy_id = easy_id | (tail[i] ? cell_q[i].id : '0);
    end
  end

  assign pick_id = op_r.pick_hardest ? cell_q[0].id : easy_id;

  // Sequencing, count and result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ins_ok_nxt    = ins_ok_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE, S_INSERT: begin
        state_nxt = accept ? S_FIND : S_IDLE;
      end
      S_FIND: begin
        state_nxt              = S_INSERT;
        out_valid_nxt          = 1'b1;
        out_data_nxt.result_id = '0;
        out_data_nxt.status    = STAT_OK;
        ins_ok_nxt             = found || !full;
        case (op_r.action)
          ACT_ADD: begin
            if (!found) begin
              if (full) begin
                out_data_nxt.status = STAT_FULL;
              end else begin
                count_nxt = count_r + 1'b1;
              end
            end
          end
          ACT_REMOVE: begin
            if (found) begin
              count_nxt = count_r - 1'b1;
            end else begin
              out_data_nxt.status = STAT_ABSENT;
            end
          end
          ACT_QUERY: begin
            if (empty) begin
              out_data_nxt.status = STAT_EMPTY;
            end else begin
              out_data_nxt.result_id = pick_id;
            end
          end
          default: out_data_nxt.status = STAT_OK;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      ins_ok_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      ins_ok_r    <= ins_ok_nxt;
    end
  end

  // Transaction and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // In the insert pass the count already includes an add not yet in the chain
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_INSERT) |-> (cell_q[0].valid == (count_r != '0)))
    else $error("head cell validity disagrees with entry count");

  a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("search cycle lasted more than one cycle");

  a_result_after_find: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("result missing after search cycle");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !out_valid)
    else $error("result without a transaction");

endmodule

[sim/min_max_priority_table_tb.sv]
`timescale 1ns / 100ps

module min_max_priority_table_tb;
  import mmpt_pkg::*;

  // Action code with no meaning in the block; must leave the table alone
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Ids drawn from a small pool so that updates, removes and a full table occur
  localparam logic [ID_WIDTH-1:0] POOL_BASE = 16'h3a00;
  localparam int POOL_SIZE = 80;

  // Mirror of the table contents and the queue of results still owed
  class table_scoreboard;
    bit                     cell_valid [CAPACITY];
    logic [ID_WIDTH-1:0]    cell_id    [CAPACITY];
    logic [LEVEL_WIDTH-1:0] cell_level [CAPACITY];
    int                     entry_count;
    out_t                   expected_results [$];
    int                     errors;

    // Cell holding id, or -1
    function int find_id(logic [ID_WIDTH-1:0] id);
      for (int i = 0; i < CAPACITY; i++) begin
        if (cell_valid[i] && cell_id[i] == id) return i;
      end
      return -1;
    endfunction

    // Any id currently stored; caller makes sure the table is not empty
    function logic [ID_WIDTH-1:0] present_id();
      int want_n;
      int seen;
      want_n = $urandom_range(entry_count - 1);
      seen = 0;
      for (int i = 0; i < CAPACITY; i++) begin
        if (cell_valid[i]) begin
          if (seen == want_n) return cell_id[i];
          seen++;
        end
      end
      return '0;
    endfunction

    // Update the table for one accepted transaction and queue its result
    function void apply_action(in_t t);
      out_t                               res;
      int                                 k;
      int                                 best;
      logic [LEVEL_WIDTH+ID_WIDTH-1:0]    key;
      logic [LEVEL_WIDTH+ID_WIDTH-1:0]    best_key;
      res = '0;
      res.status = STAT_OK;
      best_key = '0;
      case (t.action)
        ACT_ADD: begin
          k = find_id(t.entry_id);
          if (k >= 0) begin
            cell_level[k] = t.entry_level;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (!cell_valid[i] && k < 0) k = i;
            end
            if (k >= 0) begin
              cell_valid[k] = 1'b1;
              cell_id[k]    = t.entry_id;
              cell_level[k] = t.entry_level;
              entry_count++;
            end else begin
              res.status = STAT_FULL;
            end
          end
        end
        ACT_REMOVE: begin
          k = find_id(t.entry_id);
          if (k >= 0) begin
            cell_valid[k] = 1'b0;
            entry_count--;
          end else begin
            res.status = STAT_ABSENT;
          end
        end
        ACT_QUERY: begin
          // level then id as one key: hardest is the largest, easiest the smallest
          best = -1;
          for (int i = 0; i < CAPACITY; i++) begin
            if (cell_valid[i]) begin
              key = {cell_level[i], cell_id[i]};
              if (best < 0 || (t.pick_hardest ? key > best_key : key < best_key)) begin
                best = i;
                best_key = key;
              end
            end
          end
          if (best >= 0) res.result_id = cell_id[best];
          else res.status = STAT_EMPTY;
        end
        default: ;
      endcase
      expected_results.push_back(res);
    endfunction

    // Compare one result with the oldest one owed
    function void check_result(out_t got);
      out_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual id %h status %0d",
                 $time, got.result_id, got.status);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.result_id !== want.result_id) begin
        $display("%0t: result_id mismatch, expected %h, actual %h",
                 $time, want.result_id, got.result_id);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  table_scoreboard board;
  bit              idle_on = 1'b1;

  min_max_priority_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Monitor: transactions and results as seen at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) board.check_result(out_data);
      if (start && !busy) board.apply_action(in_data);
    end
  end

  function automatic in_t make_item(logic [1:0] act, logic [ID_WIDTH-1:0] id,
                                    logic [LEVEL_WIDTH-1:0] lvl, logic hard);
    in_t t;
    t.action       = act;
    t.entry_id     = id;
    t.entry_level  = lvl;
    t.pick_hardest = hard;
    return t;
  endfunction

  // Present one transaction from a falling edge and hold it until taken
  task automatic send_item(in_t t);
    while (idle_on && $urandom_range(99) < 36) begin
      start   <= 1'b0;
      in_data <= in_t'($urandom);
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Main sequence
  initial begin
    int                     phase_len [5];
    int                     add_pct   [5];
    int                     rem_pct   [5];
    int                     roll;
    int                     drain_wait;
    in_t                    t;
    phase_len = '{140, 110, 120, 80, 80};
    add_pct   = '{80, 45, 15, 70, 45};
    rem_pct   = '{8, 25, 65, 15, 30};
    board = new();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty table, extremes, ties, update, level zero, unused code
    send_item(make_item(ACT_QUERY,  16'hffff, 7'h7f, 1'b1));
    send_item(make_item(ACT_QUERY,  16'h0000, 7'h00, 1'b0));
    send_item(make_item(ACT_REMOVE, 16'h1234, 7'h7f, 1'b1));
    send_item(make_item(ACT_UNUSED, 16'hffff, 7'h7f, 1'b1));
    send_item(make_item(ACT_ADD,    16'h0000, 7'h00, 1'b0));
    send_item(make_item(ACT_ADD,    16'hffff, 7'h7f, 1'b1));
    send_item(make_item(ACT_ADD,    16'h00ff, 7'h7f, 1'b0));
    send_item(make_item(ACT_ADD,    16'h0100, 7'h00, 1'b1));
    send_item(make_item(ACT_QUERY,  16'h0000, 7'h00, 1'b1));
    send_item(make_item(ACT_QUERY,  16'hffff, 7'h7f, 1'b0));
    send_item(make_item(ACT_ADD,    16'hffff, 7'h01, 1'b0));
    send_item(make_item(ACT_QUERY,  16'h1234, 7'h55, 1'b1));
    send_item(make_item(ACT_REMOVE, 16'h00ff, 7'h00, 1'b0));
    send_item(make_item(ACT_QUERY,  16'h0000, 7'h00, 1'b1));
    send_item(make_item(ACT_REMOVE, 16'h00ff, 7'h00, 1'b0));
    send_item(make_item(ACT_REMOVE, 16'h0000, 7'h7f, 1'b1));
    send_item(make_item(ACT_QUERY,  16'h0000, 7'h00, 1'b0));
    send_item(make_item(ACT_ADD,    16'h5555, 7'h55, 1'b0));
    send_item(make_item(ACT_ADD,    16'haaaa, 7'h2a, 1'b1));
    send_item(make_item(ACT_QUERY,  16'haaaa, 7'h2a, 1'b0));
    send_item(make_item(ACT_QUERY,  16'h5555, 7'h55, 1'b1));
    send_item(make_item(ACT_UNUSED, 16'h0000, 7'h00, 1'b0));

    // Random phases: fill to full, steady mix without gaps, drain, ties, mix
    for (int phase = 0; phase < 5; phase++) begin
      idle_on = (phase != 1);
      for (int n = 0; n < phase_len[phase]; n++) begin
        t = in_t'($urandom);
        roll = $urandom_range(99);
        if (roll < add_pct[phase]) begin
          t.action = ACT_ADD;
          if ($urandom_range(3) != 0)
            t.entry_id = ID_WIDTH'(POOL_BASE + $urandom_range(POOL_SIZE - 1));
          if (phase == 3) t.entry_level = LEVEL_WIDTH'($urandom_range(3));
        end else if (roll < add_pct[phase] + rem_pct[phase]) begin
          t.action = ACT_REMOVE;
          if (board.entry_count > 0 && $urandom_range(3) != 0) t.entry_id = board.present_id();
          else if ($urandom_range(1) != 0)
            t.entry_id = ID_WIDTH'(POOL_BASE + $urandom_range(POOL_SIZE - 1));
        end else if (roll < 95) begin
          t.action = ACT_QUERY;
        end else begin
          t.action = ACT_UNUSED;
        end
        send_item(t);
      end
    end
    start <= 1'b0;

    // Drain the results still owed, then allow for the insert pass
    drain_wait = 0;
    while (board.expected_results.size() != 0 && drain_wait < 1000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (8) @(posedge clk);

    if (board.expected_results.size() != 0)
      $display("%0t: %0d results never arrived", $time, board.expected_results.size());
    if (board.errors == 0 && board.expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
rtl/mmpt_pkg.sv
rtl/mmpt_cell.sv
rtl/min_max_priority_table.sv
sim/min_max_priority_table_tb.sv
